// ----- src/sgns_pkg.sv -----
// Shared types, request codes and fixed-point constants for the skip-gram
// negative-sampling update block. No dependencies.
package sgns_pkg;

    typedef logic signed [15:0] q4_12_t;
    typedef logic [1:0]         req_code_t;

    localparam req_code_t REQ_LOAD_NODE = 2'd0;
    localparam req_code_t REQ_LOAD_CTX  = 2'd1;
    localparam req_code_t REQ_TRAIN     = 2'd2;
    localparam req_code_t REQ_READ_NODE = 2'd3;

    localparam int NODES_DEFAULT = 1024;
    localparam int DIM_DEFAULT   = 64;

    localparam logic [15:0] LR_RESET = 16'd1638;

    // Sigmoid clamp point, 10.0 in Q8.24.
    localparam int SIG_LIMIT = 10 << 24;

    // Number of exp(-2^k/64) factors and of quotient bits in the sigmoid.
    localparam int EXP_TERMS = 10;
    localparam int DIV_STEPS = 17;

    localparam logic [32:0]        E_ONE     = 33'h1_0000_0000;
    localparam logic [48:0]        NUM_ONE   = 49'h1_0000_0000_0000;
    localparam logic signed [17:0] LABEL_ONE = 18'sh10000;

    // exp(-2^k/64) in Q0.32.
    function automatic logic [31:0] exp_const(input logic [3:0] k);
        logic [31:0] c;
        unique case (k)
            4'd0:    c = 32'd4228380000;
            4'd1:    c = 32'd4162825044;
            4'd2:    c = 32'd4034748382;
            4'd3:    c = 32'd3790295335;
            4'd4:    c = 32'd3344923893;
            4'd5:    c = 32'd2605029347;
            4'd6:    c = 32'd1580030169;
            4'd7:    c = 32'd581260615;
            4'd8:    c = 32'd78665070;
            4'd9:    c = 32'd1440801;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- src/sgns_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data until the next read. No dependencies.
module sgns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/skipgram_negative_sampling_update.sv -----
// Skip-gram negative-sampling update: embedding tables, dot product, sigmoid and
// gradient step around one shared 33x33 multiplier. Uses sgns_pkg and sgns_ram.
// Loads and out-of-range items finish with done in the next cycle while busy stays low; reads go
// through a read-wait state first. Train items run one at a time and skip the exp and divide
// steps when the sigmoid clamps: the dot product streams one element a cycle, and the update
// pass steps through UM1, UM2 and UWR for each element.
// After reset the block is busy while the gradient accumulator is cleared.
module skipgram_negative_sampling_update
    import sgns_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT,
    parameter int DIM   = DIM_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [9:0]  node,
    input  logic [9:0]  target,
    input  logic        label,
    input  logic [5:0]  dim_index,
    input  q4_12_t      load_value,
    input  logic        end_of_node,
    output logic        done,
    output q4_12_t      read_value,
    output logic [15:0] score,
    output logic        saturated,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int NODE_W    = $clog2(NODES);
    localparam int DIM_W     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CNT_W     = $clog2(DIM + 1);
    localparam int Z_W       = 32 + DIM_W;
    localparam int ROW_DEPTH = NODES * (2 ** DIM_W);
    localparam int ACC_DEPTH = 2 ** DIM_W;
    localparam int ADDR_W    = NODE_W + DIM_W;

    localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(SIG_LIMIT);
    localparam logic signed [33:0]    A_MAX = 34'sd2147483647;
    localparam logic signed [33:0]    A_MIN = -34'sd2147483648;
    localparam logic signed [17:0]    C_MAX = 18'sd32767;
    localparam logic signed [17:0]    C_MIN = -18'sd32768;
    localparam logic signed [20:0]    N_MAX = 21'sd32767;
    localparam logic signed [20:0]    N_MIN = -21'sd32768;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDW   = 4'd2;
    localparam logic [3:0] S_DOT   = 4'd3;
    localparam logic [3:0] S_SIG   = 4'd4;
    localparam logic [3:0] S_EXP   = 4'd5;
    localparam logic [3:0] S_EXPW  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_GRAD  = 4'd9;
    localparam logic [3:0] S_GRADW = 4'd10;
    localparam logic [3:0] S_UM1   = 4'd11;
    localparam logic [3:0] S_UM2   = 4'd12;
    localparam logic [3:0] S_UWR   = 4'd13;

    // Control registers
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [4:0]       step_reg, step_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             e_one_reg, e_one_next;
    logic             done_reg, done_next;
    logic [15:0]      lr_reg;

    // Datapath registers
    logic signed [Z_W-1:0] z_reg, z_next;
    logic                  zneg_reg, zneg_next;
    logic [9:0]            m_reg, m_next;
    logic [31:0]           e_reg, e_next;
    logic [33:0]           den_reg, den_next;
    logic [33:0]           rem_reg, rem_next;
    logic [16:0]           num_reg, num_next;
    logic [16:0]           q_reg, q_next;
    logic [15:0]           s_reg, s_next;
    logic signed [17:0]    g_reg, g_next;
    logic signed [31:0]    a_reg, a_next;
    logic                  sat_reg, sat_next;
    logic signed [65:0]    prod_reg;
    logic [NODE_W-1:0]     node_row_reg, node_row_next;
    logic [NODE_W-1:0]     tgt_row_reg, tgt_row_next;
    logic                  label_reg, label_next;
    logic                  eon_reg, eon_next;
    q4_12_t                read_value_reg, read_value_next;
    logic [15:0]           score_reg, score_next;
    logic                  saturated_reg, saturated_next;

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    // Memory ports
    logic              node_we, node_re, ctx_we, ctx_re, acc_we, acc_re;
    logic [ADDR_W-1:0] node_waddr, node_raddr, ctx_waddr, ctx_raddr;
    logic [DIM_W-1:0]  acc_waddr, acc_raddr;
    q4_12_t            node_wdata, ctx_wdata, node_rd, ctx_rd;
    logic [31:0]       acc_wdata, acc_rd_raw;
    logic signed [31:0] acc_rd;

    // Helpers
    logic [DIM_W-1:0]   idx, idx_inc, in_dim;
    logic [CNT_W-1:0]   cnt_inc;
    logic [NODE_W-1:0]  in_row, in_tgt;
    logic               node_ok, tgt_ok, dim_ok;
    logic [Z_W-1:0]     z_mag;
    logic               exp_bit;
    logic [32:0]        e_full;
    logic [48:0]        num_init;
    logic [34:0]        rem_shift;
    logic [16:0]        q_step;
    logic signed [17:0] diff;
    logic signed [65:0] prod_sh4, prod_sh16;
    logic signed [33:0] a_sum;
    logic signed [17:0] c_sum;
    logic signed [20:0] n_sum;
    logic signed [31:0] a_sh12;
    logic               c_ov, n_ov;

    sgns_ram #(.WIDTH(16), .DEPTH(ROW_DEPTH)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rd)
    );

    sgns_ram #(.WIDTH(16), .DEPTH(ROW_DEPTH)) u_ctx_ram (
        .clk   (clk),
        .we    (ctx_we),
        .waddr (ctx_waddr),
        .wdata (ctx_wdata),
        .re    (ctx_re),
        .raddr (ctx_raddr),
        .rdata (ctx_rd)
    );

    sgns_ram #(.WIDTH(32), .DEPTH(ACC_DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rd_raw)
    );

    assign acc_rd = $signed(acc_rd_raw);

    assign idx     = cnt_reg[DIM_W-1:0];
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign idx_inc = cnt_inc[DIM_W-1:0];
    assign in_row  = NODE_W'(node);
    assign in_tgt  = NODE_W'(target);
    assign in_dim  = DIM_W'(dim_index);
    assign node_ok = 32'(node) < NODES;
    assign tgt_ok  = 32'(target) < NODES;
    assign dim_ok  = 32'(dim_index) < DIM;

    assign z_mag   = z_reg[Z_W-1] ? Z_W'(-z_reg) : Z_W'(z_reg);
    assign exp_bit = m_reg[step_reg[3:0]];
    assign e_full  = e_one_reg ? E_ONE : {1'b0, e_reg};
    // For a negative input the numerator is e * 2^16, otherwise 2^48.
    assign num_init  = zneg_reg ? {e_full, 16'd0} : NUM_ONE;
    assign rem_shift = {rem_reg, num_reg[16]};
    assign diff      = (label_reg ? LABEL_ONE : 18'sd0) - $signed({2'b00, s_reg});

    assign prod_sh4  = prod_reg >>> 4;
    assign prod_sh16 = prod_reg >>> 16;
    assign a_sum     = 34'(acc_rd) + 34'(prod_sh4);
    assign c_sum     = 18'(ctx_rd) + 18'(prod_sh16);
    assign a_sh12    = a_reg >>> 12;
    assign n_sum     = 21'(node_rd) + 21'(a_sh12);
    assign c_ov      = (c_sum > C_MAX) || (c_sum < C_MIN);
    assign n_ov      = (n_sum > N_MAX) || (n_sum < N_MIN);

    always_comb
    begin
        unique case (state_reg)
            S_DOT:
            begin
                mul_a = 33'(node_rd);
                mul_b = 33'(ctx_rd);
            end
            S_EXP:
            begin
                mul_a = $signed({1'b0, e_reg});
                mul_b = $signed({1'b0, exp_const(step_reg[3:0])});
            end
            S_GRAD:
            begin
                mul_a = $signed({17'd0, lr_reg});
                mul_b = 33'(diff);
            end
            S_UM1:
            begin
                mul_a = 33'(g_reg);
                mul_b = 33'(ctx_rd);
            end
            S_UM2:
            begin
                mul_a = 33'(g_reg);
                mul_b = 33'(node_rd);
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        v1_next         = 1'b0;
        v2_next         = 1'b0;
        e_one_next      = e_one_reg;
        done_next       = 1'b0;
        z_next          = z_reg;
        zneg_next       = zneg_reg;
        m_next          = m_reg;
        e_next          = e_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        q_next          = q_reg;
        s_next          = s_reg;
        g_next          = g_reg;
        a_next          = a_reg;
        sat_next        = sat_reg;
        node_row_next   = node_row_reg;
        tgt_row_next    = tgt_row_reg;
        label_next      = label_reg;
        eon_next        = eon_reg;
        read_value_next = read_value_reg;
        score_next      = score_reg;
        saturated_next  = saturated_reg;
        q_step          = q_reg;

        node_we    = 1'b0;
        node_waddr = {node_row_reg, idx};
        node_wdata = node_rd;
        node_re    = 1'b0;
        node_raddr = {node_row_reg, idx};
        ctx_we     = 1'b0;
        ctx_waddr  = {tgt_row_reg, idx};
        ctx_wdata  = ctx_rd;
        ctx_re     = 1'b0;
        ctx_raddr  = {tgt_row_reg, idx};
        acc_we     = 1'b0;
        acc_waddr  = idx;
        acc_wdata  = 32'd0;
        acc_re     = 1'b0;
        acc_raddr  = idx;

        unique case (state_reg)
            S_CLR:
            begin
                acc_we = 1'b1;
                if (cnt_reg == CNT_W'(DIM - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    done_next       = 1'b1;
                    read_value_next = '0;
                    score_next      = '0;
                    saturated_next  = 1'b0;
                    unique case (req_type)
                        REQ_TRAIN:
                        begin
                            if (node_ok && tgt_ok)
                            begin
                                done_next     = 1'b0;
                                node_row_next = in_row;
                                tgt_row_next  = in_tgt;
                                label_next    = label;
                                eon_next      = end_of_node;
                                cnt_next      = '0;
                                z_next        = '0;
                                sat_next      = 1'b0;
                                state_next    = S_DOT;
                            end
                        end
                        REQ_LOAD_NODE:
                        begin
                            node_we    = node_ok && dim_ok;
                            node_waddr = {in_row, in_dim};
                            node_wdata = load_value;
                        end
                        REQ_LOAD_CTX:
                        begin
                            ctx_we    = node_ok && dim_ok;
                            ctx_waddr = {in_row, in_dim};
                            ctx_wdata = load_value;
                        end
                        REQ_READ_NODE:
                        begin
                            if (node_ok && dim_ok)
                            begin
                                done_next  = 1'b0;
                                node_re    = 1'b1;
                                node_raddr = {in_row, in_dim};
                                state_next = S_RDW;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RDW:
            begin
                done_next       = 1'b1;
                read_value_next = node_rd;
                score_next      = '0;
                saturated_next  = 1'b0;
                state_next      = S_IDLE;
            end

            // Read issue, multiply and accumulate overlap in a pipeline tracked by v1 and v2.
            S_DOT:
            begin
                if (cnt_reg != CNT_W'(DIM))
                begin
                    node_re  = 1'b1;
                    ctx_re   = 1'b1;
                    v1_next  = 1'b1;
                    cnt_next = cnt_inc;
                end
                v2_next = v1_reg;
                if (v2_reg)
                begin
                    z_next = z_reg + Z_W'(prod_reg);
                end
                if (cnt_reg == CNT_W'(DIM) && !v1_reg && !v2_reg)
                begin
                    state_next = S_SIG;
                end
            end

            S_SIG:
            begin
                cnt_next = '0;
                if (z_reg > Z_LIM)
                begin
                    s_next     = 16'hFFFF;
                    state_next = S_GRAD;
                end
                else if (z_reg < -Z_LIM)
                begin
                    s_next     = 16'd0;
                    state_next = S_GRAD;
                end
                else
                begin
                    zneg_next  = z_reg[Z_W-1];
                    m_next     = z_mag[27:18];
                    e_one_next = 1'b1;
                    step_next  = '0;
                    state_next = S_EXP;
                end
            end

            // While e is still exactly one, a set bit just loads the factor.
            S_EXP:
            begin
                if (exp_bit && !e_one_reg)
                begin
                    state_next = S_EXPW;
                end
                else
                begin
                    if (exp_bit)
                    begin
                        e_next     = exp_const(step_reg[3:0]);
                        e_one_next = 1'b0;
                    end
                    if (step_reg == 5'(EXP_TERMS - 1))
                    begin
                        state_next = S_DIVI;
                    end
                    else
                    begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end

            S_EXPW:
            begin
                e_next = prod_reg[63:32];
                if (step_reg == 5'(EXP_TERMS - 1))
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = S_EXP;
                end
            end

            // The quotient is below 2^17, so the top numerator bits already
            // form a partial remainder smaller than the denominator.
            S_DIVI:
            begin
                den_next   = 34'(E_ONE) + 34'(e_full);
                rem_next   = 34'(num_init[48:17]);
                num_next   = num_init[16:0];
                q_next     = '0;
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next = 34'(rem_shift - {1'b0, den_reg});
                    q_step   = {q_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[33:0];
                    q_step   = {q_reg[15:0], 1'b0};
                end
                q_next   = q_step;
                num_next = {num_reg[15:0], 1'b0};
                if (step_reg == 5'(DIV_STEPS - 1))
                begin
                    s_next     = q_step[16] ? 16'hFFFF : q_step[15:0];
                    state_next = S_GRAD;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end

            S_GRAD:
            begin
                state_next = S_GRADW;
            end

            S_GRADW:
            begin
                g_next     = 18'(prod_sh16);
                node_re    = 1'b1;
                ctx_re     = 1'b1;
                acc_re     = 1'b1;
                state_next = S_UM1;
            end

            S_UM1:
            begin
                state_next = S_UM2;
            end

            S_UM2:
            begin
                if (a_sum > A_MAX)
                begin
                    a_next   = 32'sh7FFF_FFFF;
                    sat_next = 1'b1;
                end
                else if (a_sum < A_MIN)
                begin
                    a_next   = -32'sh8000_0000;
                    sat_next = 1'b1;
                end
                else
                begin
                    a_next = 32'(a_sum);
                end
                state_next = S_UWR;
            end

            // Write back this element and read the next one in the same cycle.
            S_UWR:
            begin
                ctx_we = 1'b1;
                if (c_sum > C_MAX)
                begin
                    ctx_wdata = 16'sh7FFF;
                end
                else if (c_sum < C_MIN)
                begin
                    ctx_wdata = -16'sh8000;
                end
                else
                begin
                    ctx_wdata = 16'(c_sum);
                end
                acc_we    = 1'b1;
                acc_wdata = eon_reg ? 32'd0 : a_reg;
                node_we   = eon_reg;
                if (n_sum > N_MAX)
                begin
                    node_wdata = 16'sh7FFF;
                end
                else if (n_sum < N_MIN)
                begin
                    node_wdata = -16'sh8000;
                end
                else
                begin
                    node_wdata = 16'(n_sum);
                end
                sat_next = sat_reg || c_ov || (eon_reg && n_ov);
                if (cnt_reg == CNT_W'(DIM - 1))
                begin
                    done_next       = 1'b1;
                    read_value_next = '0;
                    score_next      = s_reg;
                    saturated_next  = sat_next;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    node_re    = 1'b1;
                    ctx_re     = 1'b1;
                    acc_re     = 1'b1;
                    node_raddr = {node_row_reg, idx_inc};
                    ctx_raddr  = {tgt_row_reg, idx_inc};
                    acc_raddr  = idx_inc;
                    state_next = S_UM1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            step_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            e_one_reg <= 1'b1;
            done_reg  <= 1'b0;
            lr_reg    <= LR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            e_one_reg <= e_one_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                lr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= mul_p;
        z_reg          <= z_next;
        zneg_reg       <= zneg_next;
        m_reg          <= m_next;
        e_reg          <= e_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        num_reg        <= num_next;
        q_reg          <= q_next;
        s_reg          <= s_next;
        g_reg          <= g_next;
        a_reg          <= a_next;
        sat_reg        <= sat_next;
        node_row_reg   <= node_row_next;
        tgt_row_reg    <= tgt_row_next;
        label_reg      <= label_next;
        eon_reg        <= eon_next;
        read_value_reg <= read_value_next;
        score_reg      <= score_next;
        saturated_reg  <= saturated_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign score      = score_reg;
    assign saturated  = saturated_reg;

endmodule

// ----- verif/skipgram_negative_sampling_update_tb.sv -----
// Self-checking testbench for skipgram_negative_sampling_update: directed table, then random
// load, read and train items checked against an in-bench model of the embedding tables.
// Depends on sgns_pkg and the block's RTL only.
module skipgram_negative_sampling_update_tb
    import sgns_pkg::*;
();

    localparam int NODES       = NODES_DEFAULT;
    localparam int DIM         = DIM_DEFAULT;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 160;
    localparam int PHASES      = 6;
    localparam longint Z_CLAMP = 64'sd167772160;

    typedef struct packed {
        req_code_t          req;
        logic [9:0]         node;
        logic [9:0]         target;
        logic               label;
        logic [5:0]         dim;
        logic signed [15:0] value;
        logic               eon;
    } sgns_item_t;

    typedef struct packed {
        logic signed [15:0] rd;
        logic [15:0]        sc;
        logic               sat;
    } sgns_result_t;

    typedef struct packed {
        sgns_item_t   it;
        logic         typed;
        sgns_result_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [9:0]  node;
    logic [9:0]  target;
    logic        label;
    logic [5:0]  dim_index;
    q4_12_t      load_value;
    logic        end_of_node;
    logic        done;
    q4_12_t      read_value;
    logic [15:0] score;
    logic        saturated;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    skipgram_negative_sampling_update i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .node        (node),
        .target      (target),
        .label       (label),
        .dim_index   (dim_index),
        .load_value  (load_value),
        .end_of_node (end_of_node),
        .done        (done),
        .read_value  (read_value),
        .score       (score),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // Model state: both embedding tables, the shared accumulator and the step size.
    shortint     node_emb [0:NODES*DIM-1];
    shortint     ctx_emb  [0:NODES*DIM-1];
    int          grad_acc [0:DIM-1];
    logic [15:0] lr_q16 = LR_RESET;
    bit [31:0]   exp_q32 [0:9] = '{32'd4228380000, 32'd4162825044, 32'd4034748382,
                                   32'd3790295335, 32'd3344923893, 32'd2605029347,
                                   32'd1580030169, 32'd581260615, 32'd78665070,
                                   32'd1440801};

    sgns_result_t pending_results[$];
    int           node_rows[$];
    int           ctx_rows[$];
    int           node_adhoc[$];

    int errors      = 0;
    int idle_cycles = 0;
    int n_items     = 0;
    int n_loads     = 0;
    int n_reads     = 0;
    int n_trains    = 0;
    int n_mid       = 0;
    int n_sat       = 0;
    int n_rates     = 1;

    // Rows: item fields {req, node, target, label, dim, value, eon}, typed flag, result.
    dir_row_t dir_table [0:15] = '{
        '{'{REQ_LOAD_NODE, 10'd5,    10'd0,    1'b0, 6'd0,  16'sh7FFF, 1'b0}, 1'b1, '0},
        '{'{REQ_LOAD_NODE, 10'd5,    10'd0,    1'b0, 6'd63, 16'sh8000, 1'b0}, 1'b1, '0},
        '{'{REQ_LOAD_CTX,  10'd5,    10'd0,    1'b0, 6'd0,  16'sh0000, 1'b0}, 1'b1, '0},
        '{'{REQ_READ_NODE, 10'd5,    10'd0,    1'b0, 6'd0,  16'sh0000, 1'b0}, 1'b1,
          '{16'sh7FFF, 16'd0, 1'b0}},
        '{'{REQ_READ_NODE, 10'd5,    10'd0,    1'b0, 6'd63, 16'sh0000, 1'b0}, 1'b1,
          '{16'sh8000, 16'd0, 1'b0}},
        '{'{REQ_READ_NODE, 10'd1023, 10'd0,    1'b0, 6'd63, 16'sh0000, 1'b0}, 1'b1,
          '{16'sh7FFF, 16'd0, 1'b0}},
        '{'{REQ_READ_NODE, 10'd0,    10'd0,    1'b0, 6'd0,  16'sh0000, 1'b0}, 1'b1,
          '{16'sh8000, 16'd0, 1'b0}},
        '{'{REQ_TRAIN,     10'd1023, 10'd1023, 1'b1, 6'd0,  16'sh0000, 1'b0}, 1'b1,
          '{16'sh0000, 16'd65535, 1'b0}},
        '{'{REQ_TRAIN,     10'd0,    10'd1023, 1'b0, 6'd0,  16'sh0000, 1'b0}, 1'b1,
          '{16'sh0000, 16'd0, 1'b0}},
        '{'{REQ_TRAIN,     10'd1023, 10'd0,    1'b1, 6'd0,  16'sh0000, 1'b0}, 1'b1,
          '{16'sh0000, 16'd32768, 1'b0}},
        '{'{REQ_TRAIN,     10'd0,    10'd1023, 1'b1, 6'd0,  16'sh0000, 1'b1}, 1'b0, '0},
        '{'{REQ_TRAIN,     10'd1023, 10'd1023, 1'b0, 6'd0,  16'sh0000, 1'b1}, 1'b0, '0},
        '{'{REQ_TRAIN,     10'd0,    10'd0,    1'b0, 6'd0,  16'sh0000, 1'b0}, 1'b0, '0},
        '{'{REQ_READ_NODE, 10'd0,    10'd0,    1'b0, 6'd17, 16'sh0000, 1'b0}, 1'b0, '0},
        '{'{REQ_LOAD_CTX,  10'd1023, 10'd0,    1'b0, 6'd10, 16'shFFFF, 1'b0}, 1'b1, '0},
        '{'{REQ_TRAIN,     10'd1023, 10'd1023, 1'b1, 6'd0,  16'sh0000, 1'b1}, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clamp_sum(input longint v, input longint lo, input longint hi,
                                         inout bit hit);
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Sigmoid of a Q8.24 dot product as unsigned Q0.16, built from exp(-2^k/64) factors.
    function automatic logic [15:0] squash_q16(input longint z);
        bit [63:0] mag;
        bit [63:0] m;
        bit [63:0] e;
        bit [63:0] den;
        bit [63:0] s;
        if (z > Z_CLAMP)
            return 16'hFFFF;
        if (z < -Z_CLAMP)
            return 16'h0000;
        mag = (z < 0) ? -z : z;
        m   = mag >> 18;
        e   = 64'd1 << 32;
        for (int k = 0; k < 10; k++)
            if (m[k])
                e = (e * exp_q32[k]) >> 32;
        den = (64'd1 << 32) + e;
        s   = (z < 0) ? (e << 16) / den : (64'd1 << 48) / den;
        if (s > 64'd65535)
            s = 64'd65535;
        return s[15:0];
    endfunction

    function automatic sgns_result_t predict_update(input sgns_item_t it);
        sgns_result_t r;
        int           nb;
        int           cb;
        longint       z;
        longint       gq;
        longint       nv;
        longint       cv;
        longint       a;
        longint       c;
        longint       lr_l;
        longint       sc_l;
        bit           hit;
        r   = '0;
        hit = 1'b0;
        nb  = int'(it.node) * DIM;
        cb  = int'(it.target) * DIM;
        case (it.req)
            REQ_LOAD_NODE: node_emb[nb + int'(it.dim)] = it.value;
            REQ_LOAD_CTX:  ctx_emb[nb + int'(it.dim)] = it.value;
            REQ_READ_NODE: r.rd = node_emb[nb + int'(it.dim)];
            default:
            begin
                z = 0;
                for (int d = 0; d < DIM; d++)
                    z += longint'(node_emb[nb + d]) * longint'(ctx_emb[cb + d]);
                r.sc = squash_q16(z);
                lr_l = lr_q16;
                sc_l = r.sc;
                gq   = (lr_l * ((it.label ? 64'sd65536 : 64'sd0) - sc_l)) >>> 16;
                // The accumulator takes the context vector before this item's update.
                for (int d = 0; d < DIM; d++)
                begin
                    nv = node_emb[nb + d];
                    cv = ctx_emb[cb + d];
                    a  = longint'(grad_acc[d]) + ((gq * cv) >>> 4);
                    c  = cv + ((gq * nv) >>> 16);
                    grad_acc[d]     = int'(clamp_sum(a, -64'sd2147483648, 64'sd2147483647, hit));
                    ctx_emb[cb + d] = shortint'(clamp_sum(c, -32768, 32767, hit));
                end
                if (it.eon)
                begin
                    for (int d = 0; d < DIM; d++)
                    begin
                        a = longint'(node_emb[nb + d]) + (longint'(grad_acc[d]) >>> 12);
                        node_emb[nb + d] = shortint'(clamp_sum(a, -32768, 32767, hit));
                        grad_acc[d] = 0;
                    end
                end
                r.sat = hit;
            end
        endcase
        return r;
    endfunction

    function automatic sgns_item_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(sgns_item_t)-1:0];
    endfunction

    function automatic logic signed [15:0] q_value(input int unsigned sh);
        logic signed [15:0] v;
        v = 16'($urandom);
        return v >>> sh;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Holds the item on the bus until the block takes it, then records its expected result.
    task automatic send(input sgns_item_t it, input int gap, input bit typed,
                        input sgns_result_t typed_res);
        sgns_result_t model_res;
        req_type    = it.req;
        node        = it.node;
        target      = it.target;
        label       = it.label;
        dim_index   = it.dim;
        load_value  = it.value;
        end_of_node = it.eon;
        start       = 1'b1;
        do
            @(posedge clk);
        while (busy);
        model_res = predict_update(it);
        pending_results = {pending_results, (typed ? typed_res : model_res)};
        n_items++;
        case (it.req)
            REQ_TRAIN:
            begin
                n_trains++;
                if (model_res.sc != 16'd0 && model_res.sc != 16'hFFFF)
                    n_mid++;
                if (model_res.sat)
                    n_sat++;
            end
            REQ_READ_NODE: n_reads++;
            default:       n_loads++;
        endcase
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_rate(input logic [15:0] v);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_wdata = v;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        lr_q16 = v;
        n_rates++;
    endtask

    task automatic fill_row(input req_code_t req, input int row, input int unsigned sh,
                            input bit gapless);
        sgns_item_t it;
        for (int d = 0; d < DIM; d++)
        begin
            it       = noise_item();
            it.req   = req;
            it.node  = 10'(row);
            it.dim   = 6'(d);
            it.value = q_value(sh);
            send(it, gapless ? 0 : pick_gap(), 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        sgns_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no item pending: read_value %0d score %0d saturated %0b",
                         $time, $signed(read_value), score, saturated);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.rd)
                begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, $signed(want.rd), $signed(read_value));
                    errors++;
                end
                if (score !== want.sc)
                begin
                    $display("%0t: score expected %0d actual %0d", $time, want.sc, score);
                    errors++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: nothing accepted for %0d cycles", $time, idle_cycles);
            $display("skipgram_negative_sampling_update: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        sgns_item_t  it;
        logic [15:0] rate;
        int          eon_pct;
        int          r;
        int          addr;
        bit          gapless;
        start       = 1'b0;
        req_type    = REQ_LOAD_NODE;
        node        = '0;
        target      = '0;
        label       = 1'b0;
        dim_index   = '0;
        load_value  = '0;
        end_of_node = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        rst_n       = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Rows at the value extremes and an all-zero context row for the directed part.
        for (int d = 0; d < DIM; d++)
        begin
            it = noise_item();
            it.dim = 6'(d);
            it.req = REQ_LOAD_NODE; it.node = 10'd0;    it.value = 16'sh8000;
            send(it, 0, 1'b0, '0);
            it.req = REQ_LOAD_NODE; it.node = 10'd1023; it.value = 16'sh7FFF;
            send(it, 0, 1'b0, '0);
            it.req = REQ_LOAD_CTX;  it.node = 10'd1023; it.value = 16'sh7FFF;
            send(it, 0, 1'b0, '0);
            it.req = REQ_LOAD_CTX;  it.node = 10'd0;    it.value = 16'sh0000;
            send(it, pick_gap(), 1'b0, '0);
        end
        node_rows = {node_rows, 0};
        node_rows = {node_rows, 1023};
        ctx_rows  = {ctx_rows, 0};
        ctx_rows  = {ctx_rows, 1023};

        foreach (dir_table[i])
            send(dir_table[i].it, pick_gap(), dir_table[i].typed, dir_table[i].res);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       rate = 16'hFFFF;
                1:       rate = 16'h0000;
                2:       rate = 16'h0001;
                5:       rate = LR_RESET;
                default: rate = 16'($urandom);
            endcase
            write_rate(rate);
            // A rare end-of-node at full rate lets the accumulator run into its limits.
            eon_pct = (p == 0) ? 4 : $urandom_range(10, 70);
            gapless = (p == 2);
            node_rows = {node_rows, int'($urandom_range(0, NODES - 1))};
            ctx_rows  = {ctx_rows, int'($urandom_range(0, NODES - 1))};
            fill_row(REQ_LOAD_NODE, node_rows[node_rows.size()-1], $urandom_range(0, 8), gapless);
            fill_row(REQ_LOAD_CTX, ctx_rows[ctx_rows.size()-1], $urandom_range(0, 8), gapless);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 2)
                    drain_results();
                it = noise_item();
                r  = $urandom_range(0, 99);
                if (r < 45)
                begin
                    it.req    = REQ_TRAIN;
                    it.node   = 10'(node_rows[$urandom_range(0, node_rows.size()-1)]);
                    it.target = 10'(ctx_rows[$urandom_range(0, ctx_rows.size()-1)]);
                    it.eon    = ($urandom_range(0, 99) < eon_pct);
                end
                else if (r < 65)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        it.req  = REQ_LOAD_NODE;
                        it.node = 10'(node_rows[$urandom_range(0, node_rows.size()-1)]);
                    end
                    else
                    begin
                        it.req  = REQ_LOAD_CTX;
                        it.node = 10'(ctx_rows[$urandom_range(0, ctx_rows.size()-1)]);
                    end
                    it.value = q_value($urandom_range(0, 8));
                end
                else if (r < 80)
                begin
                    it.req = $urandom_range(0, 1) ? REQ_LOAD_NODE : REQ_LOAD_CTX;
                    if (it.req == REQ_LOAD_NODE)
                        node_adhoc = {node_adhoc, int'(it.node) * DIM + int'(it.dim)};
                end
                else
                begin
                    // Reads only touch elements that have been loaded.
                    it.req = REQ_READ_NODE;
                    if (node_adhoc.size() != 0 && $urandom_range(0, 1))
                    begin
                        addr    = node_adhoc[$urandom_range(0, node_adhoc.size()-1)];
                        it.node = 10'(addr / DIM);
                        it.dim  = 6'(addr % DIM);
                    end
                    else
                        it.node = 10'(node_rows[$urandom_range(0, node_rows.size()-1)]);
                end
                send(it, gapless ? 0 : pick_gap(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (40) @(negedge clk);
        $display("Ran %0d items (%0d loads, %0d reads, %0d train pairs) under %0d step sizes.",
                 n_items, n_loads, n_reads, n_trains, n_rates);
        $display("Train pairs with a score inside the sigmoid table: %0d, with a saturated sum: %0d.",
                 n_mid, n_sat);
        if (errors == 0)
            $display("skipgram_negative_sampling_update: match");
        else
            $display("skipgram_negative_sampling_update: mismatch");
        $finish;
    end

endmodule
